/* design/dhsu_pkg.sv */
// Shared constants and field layout of the detector hit stream unpacker.
package dhsu_pkg;

   localparam int MAX_CARDS = 32;
   localparam int CARD_IW   = (MAX_CARDS > 1) ? $clog2(MAX_CARDS) : 1;
   localparam int ROWS      = MAX_CARDS * 4;
   localparam int ROW_IW    = CARD_IW + 2;

   // one row per chip: 16 fast-time lanes, last hit time, mux count
   localparam int LANES     = 16;
   localparam int LAST_LSB  = LANES * 64;
   localparam int CNT_LSB   = LAST_LSB + 64;
   localparam int ROW_W     = CNT_LSB + 8;

   localparam logic [2:0] KIND_NONE   = 3'd0;
   localparam logic [2:0] KIND_HIT    = 3'd1;
   localparam logic [2:0] KIND_FLOW   = 3'd2;
   localparam logic [2:0] KIND_SCALER = 3'd3;
   localparam logic [2:0] KIND_ERROR  = 3'd4;

   localparam logic [2:0] ERR_NONE   = 3'd0;
   localparam logic [2:0] ERR_HEADER = 3'd1;
   localparam logic [2:0] ERR_TIME   = 3'd2;
   localparam logic [2:0] ERR_CARD   = 3'd3;
   localparam logic [2:0] ERR_WAVE   = 3'd4;
   localparam logic [2:0] ERR_INFO   = 3'd5;
   localparam logic [2:0] ERR_TYPE   = 3'd6;
   localparam logic [2:0] ERR_MUX    = 3'd7;

   localparam logic [1:0] TYPE_INVALID = 2'd0;
   localparam logic [1:0] TYPE_WAVE    = 2'd1;
   localparam logic [1:0] TYPE_INFO    = 2'd2;
   localparam logic [1:0] TYPE_HIT     = 2'd3;

   localparam logic [3:0] INFO_PAUSE  = 4'd2;
   localparam logic [3:0] INFO_RESUME = 4'd3;
   localparam logic [3:0] INFO_MID    = 4'd4;
   localparam logic [3:0] INFO_HIGH   = 4'd5;
   localparam logic [3:0] INFO_DISC   = 4'd6;
   localparam logic [3:0] INFO_SCALER = 4'd8;

   localparam logic       OP_HEADER = 1'b0;

   localparam logic [15:0] TAG1 = 16'h03e1;
   localparam logic [15:0] TAG2 = 16'h04e1;
   localparam logic [15:0] TAG3 = 16'h05e1;
   localparam logic [15:0] TAG4 = 16'h06e1;

   localparam logic CSR_OFFSET = 1'b0;
   localparam logic CSR_PERIOD = 1'b1;

   localparam logic [15:0] PERIOD_RESET = 16'd2000;
   localparam logic [7:0]  MUX_LIMIT    = 8'd16;

endpackage

/* design/detector_hit_stream_unpacker.sv */
// Top level of the detector hit stream unpacker.
// Takes one header or data word pair and returns exactly one result word for it. In the
// accept cycle the chip row (fast times, last hit time, mux count) and the card scaler are
// read from their RAMs; the next cycle decodes the word, writes the rows back and loads
// the output register. A new word is not taken while one is being decoded, nor while the
// output register holds a result that the sink has not yet taken. Row and
// scaler entries carry reset-cleared valid bits, so no clearing pass runs after reset.
// Configuration: csr_index 0 is time_offset, 1 is mux_period (csr_data[15:0]).
module detector_hit_stream_unpacker
   import dhsu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [191:0] req_tdata,  // data_word, time_low_word, header_word1..4
   input  logic         req_tuser,  // operation
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [295:0] rsp_tdata,  // error_code, card, channel, sample_value, vernier_flag,
                                    // range_flag, raw_time, slow_time, disc_time,
                                    // scaler_value, paused, zero fill
   output logic [2:0]   rsp_tuser,  // result_kind
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [31:0]  csr_data
);
   logic [31:0] offset_ff;
   logic [15:0] period_ff;
   logic [63:0] time_ff, time_in;
   logic        s1_valid_ff;
   logic        op_ff;
   logic [191:0] item_ff;
   logic [ROW_IW-1:0]  row_addr_ff, row_addr_in;
   logic [CARD_IW-1:0] card_addr_in;
   logic        row_valid_ff [ROWS];
   logic        sc_valid_ff [MAX_CARDS];
   logic        rsp_valid_ff;
   logic [295:0] rsp_data_ff, rsp_data_in;
   logic [2:0]  rsp_user_ff, rsp_user_in;

   logic [ROW_W-1:0] row_rd, row_cur, row_new;
   logic [63:0] sc_rd, sc_cur, sc_new;
   logic        row_we, sc_we, accept;

   assign csr_ready  = !reset;
   assign req_tready = !reset && !s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   // read addresses from the incoming word
   always_comb begin
      if (req_tdata[31:30] == TYPE_HIT) begin
         row_addr_in = {req_tdata[22 +: CARD_IW], req_tdata[21:20]};
      end else begin
         row_addr_in = {req_tdata[24 +: CARD_IW], req_tdata[17:16]};
      end
      card_addr_in = req_tdata[24 +: CARD_IW];
   end

   dhsu_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (row_addr_ff),
      .wr_data (row_new),
      .rd_en   (accept),
      .rd_addr (row_addr_in),
      .rd_data (row_rd)
   );

   dhsu_ram #(.WIDTH(64), .DEPTH(MAX_CARDS)) u_sc_ram (
      .clock   (clock),
      .wr_en   (sc_we),
      .wr_addr (item_ff[24 +: CARD_IW]),
      .wr_data (sc_new),
      .rd_en   (accept),
      .rd_addr (card_addr_in),
      .rd_data (sc_rd)
   );

   // decode stage
   logic [31:0] d, lo;
   logic [63:0] t_lo, off64, fast, last, corr, raw;
   logic [7:0]  cnt, cnt_next;
   logic [23:0] prod;
   logic [2:0]  kind, err;
   logic [6:0]  card;
   logic [3:0]  lane;
   logic        paused;
   logic [63:0] scal;

   always_comb begin
      d       = item_ff[31:0];
      lo      = item_ff[63:32];
      off64   = {{32{offset_ff[31]}}, offset_ff};
      t_lo    = {time_ff[63:28], lo[27:0]};
      time_in = time_ff;
      row_cur = row_valid_ff[row_addr_ff] ? row_rd : '0;
      sc_cur  = sc_valid_ff[item_ff[24 +: CARD_IW]] ? sc_rd : '0;
      row_new = row_cur;
      sc_new  = sc_cur;
      row_we  = 1'b0;
      sc_we   = 1'b0;
      lane    = d[19:16];
      fast    = row_cur[{lane, 6'd0} +: 64];
      last    = row_cur[LAST_LSB +: 64];
      cnt     = row_cur[CNT_LSB +: 8];
      prod    = '0;
      cnt_next = cnt;
      corr    = t_lo;
      kind    = KIND_NONE;
      err     = ERR_NONE;
      card    = '0;
      raw     = '0;
      paused  = 1'b0;
      scal    = '0;
      if (op_ff == OP_HEADER) begin
         if (item_ff[95:80] != TAG1 || item_ff[127:112] != TAG2
             || item_ff[159:144] != TAG3 || item_ff[191:176] != TAG4) begin
            kind = KIND_ERROR;
            err  = ERR_HEADER;
         end else begin
            time_in = {item_ff[175:160], item_ff[143:128], item_ff[111:96], item_ff[79:64]}
                      + off64;
         end
      end else if (lo[31:28] != 4'd0) begin
         kind = KIND_ERROR;
         err  = ERR_TIME;
      end else begin
         time_in = t_lo;
         unique case (d[31:30])
            TYPE_HIT: begin
               if ({1'b0, d[27:22]} >= 7'(MAX_CARDS)) begin
                  kind = KIND_ERROR;
                  err  = ERR_CARD;
               end else begin
                  if (last != 64'd0) begin
                     if (t_lo - last == {48'd0, period_ff}) begin
                        cnt_next = cnt + 8'd1;
                        // count wraps at 8 bits before it scales the period
                        prod     = {8'd0, period_ff} * {16'd0, cnt_next};
                        corr     = t_lo - {40'd0, prod};
                        if (cnt_next > MUX_LIMIT) err = ERR_MUX;
                     end else begin
                        cnt_next = '0;
                     end
                  end
                  row_new[{lane, 6'd0} +: 64] = '0;
                  row_new[LAST_LSB +: 64]     = t_lo;
                  row_new[CNT_LSB +: 8]       = cnt_next;
                  row_we = 1'b1;
                  kind   = KIND_HIT;
                  card   = {1'b0, d[27:22]} + 7'd1;
                  raw    = t_lo;
               end
            end
            TYPE_INFO: begin
               if ({1'b0, d[29:24]} >= 7'(MAX_CARDS)) begin
                  kind = KIND_ERROR;
                  err  = ERR_CARD;
               end else begin
                  unique case (d[23:20])
                     INFO_PAUSE, INFO_RESUME: begin
                        time_in = {time_ff[63:48], d[19:0], lo[27:0]};
                        kind    = KIND_FLOW;
                        card    = {1'b0, d[29:24]} + 7'd1;
                        raw     = time_in;
                        paused  = (d[23:20] == INFO_PAUSE);
                     end
                     INFO_MID: time_in = {time_ff[63:48], d[19:0], lo[27:0]};
                     INFO_HIGH: time_in = {d[15:0], time_ff[47:28], lo[27:0]};
                     INFO_DISC: begin
                        if (d[19:18] == 2'd0) begin
                           for (int i = 0; i < LANES; i++) begin
                              if (d[i]) row_new[i*64 +: 64] = t_lo;
                           end
                           row_we = 1'b1;
                        end
                     end
                     INFO_SCALER: begin
                        if (d[19:18] == 2'd0) begin
                           sc_new[{d[17:16], 4'd0} +: 16] = d[15:0];
                           sc_we = 1'b1;
                           if (d[17:16] == 2'd2) begin
                              kind = KIND_SCALER;
                              card = {1'b0, d[29:24]} + 7'd1;
                              raw  = t_lo;
                              scal = sc_new;
                           end
                        end
                     end
                     default: begin
                        kind = KIND_ERROR;
                        err  = ERR_INFO;
                     end
                  endcase
               end
            end
            TYPE_WAVE: begin
               kind = KIND_ERROR;
               err  = ERR_WAVE;
            end
            default: begin
               kind = KIND_ERROR;
               err  = ERR_TYPE;
            end
         endcase
      end
      row_we = row_we && s1_valid_ff;
      sc_we  = sc_we && s1_valid_ff;
      rsp_user_in = kind;
      if (kind == KIND_HIT) begin
         rsp_data_in = {5'd0, 1'b0, 64'd0, fast, corr, raw, d[28], d[29], d[15:0],
                        d[21:16], card, err};
      end else begin
         rsp_data_in = {5'd0, paused, scal, 64'd0, 64'd0, raw, 1'b0, 1'b0, 16'd0,
                        6'd0, card, err};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         period_ff    <= PERIOD_RESET;
         time_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ROWS; i++) row_valid_ff[i] <= 1'b0;
         for (int i = 0; i < MAX_CARDS; i++) sc_valid_ff[i] <= 1'b0;
      end else begin
         if (csr_valid) begin
            if (csr_index == CSR_OFFSET) offset_ff <= csr_data;
            if (csr_index == CSR_PERIOD) period_ff <= csr_data[15:0];
         end
         s1_valid_ff <= accept;
         if (s1_valid_ff) begin
            time_ff      <= time_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (row_we) row_valid_ff[row_addr_ff] <= 1'b1;
         if (sc_we) sc_valid_ff[item_ff[24 +: CARD_IW]] <= 1'b1;
      end
   end

   // payload: hold the word and the row address; load the result data and kind
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req_tuser;
         item_ff     <= req_tdata;
         row_addr_ff <= row_addr_in;
      end
      if (s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
endmodule

/* design/dhsu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dhsu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* bench/tb.sv */
// Self-checking testbench for the detector hit stream unpacker.
`timescale 1ns / 1ps

module tb;
   import dhsu_pkg::*;

   // packed from the top: kind, then the data fields from the highest bit down
   typedef struct packed {
      logic [2:0]  kind;
      logic        paused;
      logic [63:0] scal;
      logic [63:0] fast;
      logic [63:0] slow;
      logic [63:0] raw;
      logic        rng;
      logic        vern;
      logic [15:0] sample;
      logic [5:0]  chan;
      logic [6:0]  card;
      logic [2:0]  err;
   } hit_rec_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [191:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [295:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_index = 1'b0;
   logic [31:0]  csr_data = '0;

   detector_hit_stream_unpacker dut (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [31:0] offset_reg = '0;
   logic [15:0] period_reg = PERIOD_RESET;
   logic [63:0] cur_time = '0;
   logic [63:0] fast_mem [MAX_CARDS*64];
   logic [63:0] chip_last [MAX_CARDS*4];
   logic [7:0]  mux_cnt [MAX_CARDS*4];
   logic [63:0] scaler_mem [MAX_CARDS];

   hit_rec_type pending_recs[$];
   int       error_count = 0;
   bit       idle_on = 1'b1;
   int       quiet_cycles = 0;

   initial begin
      foreach (fast_mem[i]) fast_mem[i] = '0;
      foreach (chip_last[i]) chip_last[i] = '0;
      foreach (mux_cnt[i]) mux_cnt[i] = '0;
      foreach (scaler_mem[i]) scaler_mem[i] = '0;
   end

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      error_count++;
   endtask

   task automatic decode_word(input logic op, input logic [191:0] pl, output hit_rec_type r);
      logic [31:0] d, lo;
      logic [5:0]  card0, ch;
      logic [3:0]  code;
      logic [19:0] field;
      logic [3:0]  part;
      int          fi, ci, c;
      d = pl[31:0];
      lo = pl[63:32];
      r = '0;
      if (op == OP_HEADER) begin
         if (pl[95:80] != TAG1 || pl[127:112] != TAG2 || pl[159:144] != TAG3 ||
             pl[191:176] != TAG4) begin
            r.kind = KIND_ERROR; r.err = ERR_HEADER; return;
         end
         cur_time = {pl[175:160], pl[143:128], pl[111:96], pl[79:64]}
                    + {{32{offset_reg[31]}}, offset_reg};
         return;
      end
      if (lo[31:28] != 4'd0) begin
         r.kind = KIND_ERROR; r.err = ERR_TIME; return;
      end
      cur_time[27:0] = lo[27:0];
      case (d[31:30])
         TYPE_HIT: begin
            card0 = d[27:22];
            ch = d[21:16];
            if (card0 >= MAX_CARDS) begin
               r.kind = KIND_ERROR; r.err = ERR_CARD; return;
            end
            fi = card0 * 64 + ch;
            ci = card0 * 4 + ch[5:4];
            r.fast = fast_mem[fi];
            fast_mem[fi] = '0;
            r.slow = cur_time;
            if (chip_last[ci] != 0) begin
               if (cur_time - chip_last[ci] == {48'd0, period_reg}) begin
                  mux_cnt[ci] = mux_cnt[ci] + 8'd1;
                  r.slow = cur_time - {48'd0, period_reg} * {56'd0, mux_cnt[ci]};
                  if (mux_cnt[ci] > MUX_LIMIT) r.err = ERR_MUX;
               end else begin
                  mux_cnt[ci] = '0;
               end
            end
            chip_last[ci] = cur_time;
            r.kind = KIND_HIT;
            r.card = card0 + 7'd1;
            r.chan = ch;
            r.sample = d[15:0];
            r.vern = d[29];
            r.rng = d[28];
            r.raw = cur_time;
         end
         TYPE_INFO: begin
            card0 = d[29:24];
            code = d[23:20];
            field = d[19:0];
            part = field[19:16];
            if (card0 >= MAX_CARDS) begin
               r.kind = KIND_ERROR; r.err = ERR_CARD; return;
            end
            case (code)
               INFO_PAUSE, INFO_RESUME, INFO_MID: begin
                  cur_time = {cur_time[63:48], field, lo[27:0]};
                  if (code != INFO_MID) begin
                     r.kind = KIND_FLOW;
                     r.card = card0 + 7'd1;
                     r.raw = cur_time;
                     r.paused = (code == INFO_PAUSE);
                  end
               end
               INFO_HIGH: cur_time = {field[15:0], cur_time[47:28], lo[27:0]};
               INFO_DISC: begin
                  for (int i = 0; i < 16; i++) begin
                     c = part * 16 + i;
                     if (field[i] && c < 64) fast_mem[card0 * 64 + c] = cur_time;
                  end
               end
               INFO_SCALER: begin
                  if (part < 4) begin
                     scaler_mem[card0][part*16 +: 16] = field[15:0];
                     if (part == 2) begin
                        r.kind = KIND_SCALER;
                        r.card = card0 + 7'd1;
                        r.raw = cur_time;
                        r.scal = scaler_mem[card0];
                     end
                  end
               end
               default: begin
                  r.kind = KIND_ERROR; r.err = ERR_INFO;
               end
            endcase
         end
         TYPE_WAVE: begin r.kind = KIND_ERROR; r.err = ERR_WAVE; end
         default: begin r.kind = KIND_ERROR; r.err = ERR_TYPE; end
      endcase
   endtask

   task automatic send_word(input logic op, input logic [31:0] d, input logic [31:0] lo,
                            input logic [127:0] hdr);
      hit_rec_type r;
      if (idle_on && $urandom_range(99) < 21) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = op;
      req_tdata = {hdr, lo, d};
      do @(posedge clock); while (!req_tready);
      decode_word(op, req_tdata, r);
      pending_recs.push_back(r);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic csr_write(input logic idx, input logic [31:0] val);
      wait (pending_recs.size() == 0);
      repeat (4) @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_OFFSET) offset_reg = val;
      else period_reg = val[15:0];
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [127:0] good_hdr(input logic [63:0] t);
      return {TAG4, t[63:48], TAG3, t[47:32], TAG2, t[31:16], TAG1, t[15:0]};
   endfunction

   function automatic logic [31:0] info_w(input logic [5:0] card0, input logic [3:0] code,
                                          input logic [19:0] field);
      return {TYPE_INFO, card0, code, field};
   endfunction

   function automatic logic [31:0] hit_w(input logic [5:0] card0, input logic [5:0] ch,
                                         input logic [15:0] s);
      return {TYPE_HIT, 2'($urandom), card0, ch, s};
   endfunction

   // receiver
   always @(negedge clock)
      rsp_tready <= idle_on ? ($urandom_range(99) >= 21) : 1'b1;

   always @(posedge clock) begin
      hit_rec_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata[290:0]};
         if (pending_recs.size() == 0) begin
            report("unexpected word", {61'd0, rsp_tuser}, 64'd0);
         end else begin
            want = pending_recs.pop_front();
            if (got.kind !== want.kind) report("kind", got.kind, want.kind);
            if (got.err !== want.err) report("error_code", got.err, want.err);
            if (got.card !== want.card) report("card", got.card, want.card);
            if (got.chan !== want.chan) report("channel", got.chan, want.chan);
            if (got.sample !== want.sample) report("sample", got.sample, want.sample);
            if (got.vern !== want.vern) report("vernier", got.vern, want.vern);
            if (got.rng !== want.rng) report("range", got.rng, want.rng);
            if (got.raw !== want.raw) report("raw_time", got.raw, want.raw);
            if (got.slow !== want.slow) report("slow_time", got.slow, want.slow);
            if (got.fast !== want.fast) report("disc_time", got.fast, want.fast);
            if (got.scal !== want.scal) report("scaler", got.scal, want.scal);
            if (got.paused !== want.paused) report("paused", got.paused, want.paused);
         end
      end
   end

   // watchdog on accepted words, responses and configuration writes
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic test_directed();
      send_word(OP_HEADER, '0, '0, good_hdr(64'h0123_4567_89ab_cdef));
      send_word(OP_HEADER, '0, '0, good_hdr('1));
      send_word(OP_HEADER, '0, '0, good_hdr(64'h0) ^ (128'h1 << 16));
      send_word(OP_HEADER, '0, '0, good_hdr(64'h0) ^ (128'h1 << 63));
      send_word(OP_HEADER, '0, '0, good_hdr(64'h0) ^ (128'h1 << 111));
      send_word(OP_HEADER, '0, '0, good_hdr(64'h0) ^ (128'h1 << 127));
      send_word(1'b1, hit_w(0, 0, 0), 32'hf000_0000, '0);
      send_word(1'b1, hit_w(MAX_CARDS, 5, 1), 32'h0fff_ffff, '0);
      send_word(1'b1, info_w(6'h3f, INFO_PAUSE, 0), 32'd10, '0);
      send_word(1'b1, {TYPE_WAVE, 30'h3fff_ffff}, 32'd11, '0);
      send_word(1'b1, {TYPE_INVALID, 30'h0}, 32'd12, '0);
      send_word(1'b1, info_w(1, 4'd15, 20'hfffff), 32'd13, '0);
      send_word(1'b1, info_w(2, INFO_PAUSE, 20'h12345), 32'd14, '0);
      send_word(1'b1, info_w(2, INFO_RESUME, 20'hfffff), 32'd15, '0);
      send_word(1'b1, info_w(3, INFO_MID, 20'habcde), 32'd16, '0);
      send_word(1'b1, info_w(3, INFO_HIGH, 20'h0ffff), 32'd17, '0);
      send_word(1'b1, info_w(MAX_CARDS - 1, INFO_DISC, 20'h3ffff), 32'd18, '0);
      send_word(1'b1, info_w(MAX_CARDS - 1, INFO_DISC, 20'h4ffff), 32'd19, '0);
      send_word(1'b1, hit_w(MAX_CARDS - 1, 63, 16'hffff), 32'd20, '0);
      send_word(1'b1, hit_w(MAX_CARDS - 1, 63, 16'h0), 32'd21, '0);
      for (int p = 0; p < 4; p++)
         send_word(1'b1, info_w(4, INFO_SCALER, {4'(p), 16'hffff - 16'(p)}), 32'd22, '0);
      send_word(1'b1, info_w(4, INFO_SCALER, {4'd5, 16'h1234}), 32'd23, '0);
   endtask

   // chains of hits on one chip spaced by the period, long enough to overflow
   task automatic test_mux_chain(input int len);
      logic [5:0] card0, ch;
      int         ci;
      card0 = $urandom_range(MAX_CARDS - 1);
      ch = $urandom;
      ci = card0 * 4 + ch[5:4];
      send_word(OP_HEADER, '0, '0, good_hdr({$urandom, 4'd0, 28'($urandom_range(1000, 9999))}));
      for (int k = 0; k < len; k++) begin
         send_word(1'b1, hit_w(card0, {ch[5:4], 4'($urandom)}, $urandom),
                   {4'd0, 28'(cur_time + period_reg)}, '0);
      end
   endtask

   task automatic test_random(input int n);
      int          r, ci;
      logic [5:0]  card0, ch;
      logic [31:0] lo;
      logic [3:0]  code;
      logic [19:0] field;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(99);
         card0 = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(3));
         lo = {($urandom_range(19) == 0) ? 4'($urandom) : 4'd0, 28'($urandom)};
         if (r < 10) begin
            if ($urandom_range(9) < 8)
               send_word(OP_HEADER, $urandom, $urandom, good_hdr({$urandom, $urandom}));
            else
               send_word(OP_HEADER, $urandom, $urandom, {$urandom, $urandom, $urandom, $urandom});
         end else if (r < 15) begin
            send_word(1'($urandom), $urandom, $urandom, {$urandom, $urandom, $urandom, $urandom});
         end else if (r < 60) begin
            ch = $urandom;
            ci = (card0 % MAX_CARDS) * 4 + ch[5:4];
            if ($urandom_range(9) < 4) lo = {4'd0, 28'(chip_last[ci] + period_reg)};
            send_word(1'b1, hit_w(card0, ch, $urandom), lo, '0);
         end else if (r < 92) begin
            case ($urandom_range(7))
               0: code = INFO_PAUSE;
               1: code = INFO_RESUME;
               2: code = INFO_MID;
               3: code = INFO_HIGH;
               4: code = INFO_DISC;
               5, 6: code = INFO_SCALER;
               default: code = $urandom;
            endcase
            field = $urandom;
            if (code == INFO_SCALER || code == INFO_DISC) field[19:16] = $urandom_range(4);
            send_word(1'b1, info_w(card0, code, field), lo, '0);
         end else begin
            send_word(1'b1, {1'b0, 31'($urandom)}, lo, '0);
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      csr_write(CSR_OFFSET, 32'h7fff_ffff);
      csr_write(CSR_PERIOD, 32'd1);
      test_mux_chain(20);
      test_random(300);
      csr_write(CSR_OFFSET, 32'h8000_0000);
      csr_write(CSR_PERIOD, 32'h0000_ffff);
      test_mux_chain(19);
      idle_on = 1'b0;
      test_random(300);
      idle_on = 1'b1;
      csr_write(CSR_OFFSET, $urandom);
      csr_write(CSR_PERIOD, $urandom_range(1, 65535));
      test_mux_chain(18);
      test_random(500);
      csr_write(CSR_OFFSET, 32'd0);
      csr_write(CSR_PERIOD, {16'd0, PERIOD_RESET});
      test_random(500);
      wait (pending_recs.size() == 0);
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
